// ----- hdl/opn_pkg.sv -----
// Shared types and constants for the octave Perlin noise block.
`timescale 1ns / 1ps
`default_nettype none

package opn_pkg;

    // Permutation table
    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = 8;
    localparam int HASH_W     = 3;

    // Coordinates: signed Q16.16, only the low 24 bits matter for cell and fraction
    localparam int COORD_W    = 32;
    localparam int COORD_FRAC = 16;
    localparam int COORD_KEEP = 24;

    // Configuration registers
    localparam int OCT_CNT_W = 4;
    localparam int PERS_W    = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_PERSISTENCE  = 1'b1;

    localparam logic [OCT_CNT_W-1:0] OCT_CNT_RESET = 4'd4;
    localparam logic [PERS_W-1:0]    PERS_RESET    = 16'h8000;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Octave amplitude, Q1.16
    localparam int             AMP_W   = 17;
    localparam logic [16:0]    AMP_ONE = 17'h10000;

    // Result
    localparam int              OUT_W   = 18;
    localparam logic [17:0]     OUT_MAX = 18'h1FFFF;
    localparam logic [17:0]     Q_LIMIT = 18'h20000;

    // Divider: first step is the overflow check, then one quotient bit per step
    localparam int QUOT_W    = 18;
    localparam int DIV_STEPS = QUOT_W + 1;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic busy;
        logic done;
    } opn_div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GX,
        ST_GX1,
        ST_X3,
        ST_X4,
        ST_Y1,
        ST_Y2,
        ST_Y3,
        ST_Y4,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4,
        ST_ACC,
        ST_AMP,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_FIN
    } opn_state_t;

endpackage

`default_nettype wire

// ----- hdl/opn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module opn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/opn_mul.sv -----
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module opn_mul #(
    parameter int W = 22
) (
    input  wire logic                  aclk,
    input  wire logic signed [W-1:0]   mul_a,
    input  wire logic signed [W-1:0]   mul_b,
    output logic      signed [2*W-1:0] mul_p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
    end

    assign mul_p = p_reg;

endmodule

`default_nettype wire

// ----- hdl/opn_div.sv -----
// Restoring divider, one quotient bit per cycle, with overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module opn_div
    import opn_pkg::*;
#(
    parameter int DVD_W = 39,
    parameter int DVS_W = 21
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DVS_W-1:0]   divisor,
    output opn_div_stat_t           stat,
    output logic      [QUOT_W-1:0]  quot,
    output logic                    ovf
);

    localparam int CW = ((DVD_W > DVS_W + QUOT_W) ? DVD_W : DVS_W + QUOT_W) + 1;

    logic [CW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        den_reg, den_next;
    logic [QUOT_W:0]      q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ge;

    assign ge = (rem_reg >= den_reg);

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = CW'(dividend);
            // first compare is against divisor * 2^QUOT_W: a hit means overflow
            den_next  = CW'(divisor) << QUOT_W;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_reg - den_reg) : rem_reg;
            den_next = den_reg >> 1;
            q_next   = {q_reg[QUOT_W-1:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg[QUOT_W-1:0];
    assign ovf       = q_reg[QUOT_W];

endmodule

`default_nettype wire

// ----- hdl/octave_perlin_noise_2d.sv -----
// Octave gradient noise top level: sequencer, datapath, table and configuration port.
`timescale 1ns / 1ps
`default_nettype none

// Fractal 2D Perlin noise. A load word (opcode 0) writes one byte of the
// 256-entry permutation table and gives no result; every entry an
// evaluation may touch must be loaded first. An evaluate word (opcode 1)
// takes a signed Q16.16 point and returns one Q2.16 value, the
// persistence-weighted octave sum divided by the sum of weights, saturated.
// The single shared multiplier does all fade, interpolation and amplitude
// products one per cycle, and the divider at the end gives one quotient bit
// per cycle. s_ready is low while an item is in progress; a finished result
// waits in the output register while the next word is taken. octave_count
// and persistence are written through the APB port; the user must write
// them only while the block is idle, the block itself does not enforce it.
module octave_perlin_noise_2d
    import opn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_opcode,
    input  wire logic [7:0]                s_table_index,
    input  wire logic [7:0]                s_table_value,
    input  wire logic signed [COORD_W-1:0] s_coord_x,
    input  wire logic signed [COORD_W-1:0] s_coord_y,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [OUT_W-1:0]        m_noise_value,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output logic      [PDATA_W-1:0]        prdata,
    output logic                           pready
);

    localparam int F          = FRAC_BITS;
    localparam int UP_SHIFT   = (F >= COORD_FRAC) ? (F - COORD_FRAC) : 0;
    localparam int DOWN_SHIFT = (F < COORD_FRAC) ? (COORD_FRAC - F) : 0;
    localparam int FW_W       = (F > COORD_FRAC) ? F : COORD_FRAC;
    localparam int MW         = (F + 6 > 18) ? (F + 6) : 18;
    localparam int PW         = 2 * MW;
    localparam int GW         = F + 3;
    localparam int OCT_W      = $clog2(MAX_OCTAVES + 1);
    localparam int TOT_W      = F + 19 + OCT_W;
    localparam int WT_W       = AMP_W + OCT_W;
    localparam int DVD_W      = TOT_W + DOWN_SHIFT;
    localparam int DVS_W      = WT_W + UP_SHIFT;

    localparam logic signed [GW-1:0] ONE_G       = GW'(2 ** F);
    localparam logic        [F:0]    FADE_ONE    = (F + 1)'(2 ** F);
    localparam logic signed [MW-1:0] TEN_ONE     = MW'(10 * (2 ** F));
    localparam logic signed [MW-1:0] FIFTEEN_ONE = MW'(15 * (2 ** F));

    // ---------------------------------------------------------------- registers
    opn_state_t state_reg, state_next;

    logic [OCT_CNT_W-1:0]   oct_count_reg, oct_count_next;
    logic [PERS_W-1:0]      persist_reg, persist_next;

    logic [COORD_KEEP-1:0]  cx_reg, cx_next;
    logic [COORD_KEEP-1:0]  cy_reg, cy_next;
    logic [OCT_W-1:0]       n_reg, n_next;
    logic [OCT_W-1:0]       oct_reg, oct_next;
    logic [AMP_W-1:0]       amp_reg, amp_next;
    logic signed [TOT_W-1:0] total_reg, total_next;
    logic [WT_W-1:0]        weight_reg, weight_next;
    logic [TABLE_AW-1:0]    ha_reg, ha_next;
    logic [TABLE_AW-1:0]    hb_reg, hb_next;
    logic [HASH_W-1:0]      h_aa_reg, h_aa_next;
    logic [HASH_W-1:0]      h_ab_reg, h_ab_next;
    logic [HASH_W-1:0]      h_ba_reg, h_ba_next;
    logic [HASH_W-1:0]      h_bb_reg, h_bb_next;
    logic [F-1:0]           t3_reg, t3_next;
    logic [F:0]             fu_reg, fu_next;
    logic [F:0]             fv_reg, fv_next;
    logic signed [GW-1:0]   lo_reg, lo_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0] m_value_reg, m_value_next;

    // ---------------------------------------------------------------- shared units
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   mul_p;
    logic [TABLE_AW-1:0]    ram_rd_addr;
    logic [7:0]             ram_rd_data;
    logic                   ram_wr_en;
    logic                   div_start;
    opn_div_stat_t          div_stat;
    logic [QUOT_W-1:0]      div_quot;
    logic                   div_ovf;
    logic [DVD_W-1:0]       div_dividend;
    logic [DVS_W-1:0]       div_divisor;

    opn_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (s_table_index),
        .wr_data (s_table_value),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    opn_mul #(
        .W (MW)
    ) u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    opn_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quot     (div_quot),
        .ovf      (div_ovf)
    );

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [GW-1:0] grad(
        input logic [HASH_W-1:0]   h,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y
    );
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        logic signed [GW-1:0] su;
        logic signed [GW-1:0] sv;
        u  = h[2] ? y : x;
        v  = h[2] ? x : y;
        su = h[0] ? -u : u;
        sv = h[1] ? -v : v;
        return su + sv;
    endfunction

    logic                   s_accept;
    logic                   cfg_wr;
    logic                   last_oct;
    logic [FW_W-1:0]        fx_w, fy_w;
    logic [F-1:0]           fx, fy;
    logic signed [MW-1:0]   fxm, fym;
    logic signed [MW-1:0]   sixt_x, sixt_y;
    logic signed [PW-1:0]   p_sh;
    logic [F-1:0]           p_hi;
    logic [F:0]             fade_res;
    logic signed [MW-1:0]   inner;
    logic signed [GW-1:0]   x0g, x1g, y0g, y1g;
    logic signed [GW-1:0]   g_aa, g_ab, g_ba, g_bb;
    logic signed [GW-1:0]   lerp_add, hi_calc, nv_calc;
    logic [TABLE_AW-1:0]    gx, gy;
    logic [OCT_W-1:0]       n_sel;
    logic [TOT_W-1:0]       mag;
    logic [QUOT_W-1:0]      q_sat;

    assign s_accept  = s_valid && s_ready;
    assign ram_wr_en = s_accept && (s_opcode == OP_LOAD);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign last_oct  = (oct_reg == n_reg - OCT_W'(1));

    assign gx = cx_reg[COORD_KEEP-1:COORD_FRAC];
    assign gy = cy_reg[COORD_KEEP-1:COORD_FRAC];

    // fraction moved from 16 bits to the working precision
    assign fx_w = (FW_W'(cx_reg[COORD_FRAC-1:0]) << UP_SHIFT) >> DOWN_SHIFT;
    assign fy_w = (FW_W'(cy_reg[COORD_FRAC-1:0]) << UP_SHIFT) >> DOWN_SHIFT;
    assign fx   = fx_w[F-1:0];
    assign fy   = fy_w[F-1:0];
    assign fxm  = $signed(MW'(fx));
    assign fym  = $signed(MW'(fy));

    assign sixt_x = (fxm <<< 2) + (fxm <<< 1) - FIFTEEN_ONE;
    assign sixt_y = (fym <<< 2) + (fym <<< 1) - FIFTEEN_ONE;

    assign p_sh  = mul_p >>> F;
    assign p_hi  = mul_p[2*F-1:F];
    assign inner = MW'(p_sh) + TEN_ONE;

    always_comb begin
        if (p_sh[PW-1]) begin
            fade_res = '0;
        end else if (p_sh > PW'(ONE_G)) begin
            fade_res = FADE_ONE;
        end else begin
            fade_res = p_sh[F:0];
        end
    end

    assign x0g = $signed(GW'(fx));
    assign y0g = $signed(GW'(fy));
    assign x1g = x0g - ONE_G;
    assign y1g = y0g - ONE_G;

    assign g_aa = grad(h_aa_reg, x0g, y0g);
    assign g_ba = grad(h_ba_reg, x1g, y0g);
    assign g_ab = grad(h_ab_reg, x0g, y1g);
    assign g_bb = grad(h_bb_reg, x1g, y1g);

    assign lerp_add = GW'(p_sh);
    assign hi_calc  = g_ab + lerp_add;
    assign nv_calc  = lo_reg + lerp_add;

    always_comb begin
        if (oct_count_reg == '0) begin
            n_sel = OCT_W'(1);
        end else if (int'(oct_count_reg) > MAX_OCTAVES) begin
            n_sel = OCT_W'(MAX_OCTAVES);
        end else begin
            n_sel = OCT_W'(oct_count_reg);
        end
    end

    assign mag          = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
    assign div_dividend = DVD_W'(mag) << DOWN_SHIFT;
    assign div_divisor  = DVS_W'(weight_reg) << UP_SHIFT;

    assign q_sat = (div_ovf || (div_quot > Q_LIMIT)) ? Q_LIMIT : div_quot;

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_opcode == OP_EVAL)) begin
                    state_next = ST_GX;
                end
            end
            ST_GX:       state_next = ST_GX1;
            ST_GX1:      state_next = ST_X3;
            ST_X3:       state_next = ST_X4;
            ST_X4:       state_next = ST_Y1;
            ST_Y1:       state_next = ST_Y2;
            ST_Y2:       state_next = ST_Y3;
            ST_Y3:       state_next = ST_Y4;
            ST_Y4:       state_next = ST_L1;
            ST_L1:       state_next = ST_L2;
            ST_L2:       state_next = ST_L3;
            ST_L3:       state_next = ST_L4;
            ST_L4:       state_next = ST_ACC;
            ST_ACC:      state_next = ST_AMP;
            ST_AMP:      state_next = last_oct ? ST_DIV_LOAD : ST_GX;
            ST_DIV_LOAD: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- sequencer outputs
    // each state from ST_GX to ST_ACC issues one product; the following state consumes it
    always_comb begin
        s_ready     = 1'b0;
        div_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        ram_rd_addr = gx;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_GX: begin
                mul_a = fxm;
                mul_b = fxm;
            end
            ST_GX1: begin
                ram_rd_addr = gx + TABLE_AW'(1);
                mul_a       = $signed(MW'(p_hi));
                mul_b       = fxm;
            end
            ST_X3: begin
                ram_rd_addr = ha_reg;
                mul_a       = sixt_x;
                mul_b       = fxm;
            end
            ST_X4: begin
                ram_rd_addr = ha_reg + TABLE_AW'(1);
                mul_a       = $signed(MW'(t3_reg));
                mul_b       = inner;
            end
            ST_Y1: begin
                ram_rd_addr = hb_reg;
                mul_a       = fym;
                mul_b       = fym;
            end
            ST_Y2: begin
                ram_rd_addr = hb_reg + TABLE_AW'(1);
                mul_a       = $signed(MW'(p_hi));
                mul_b       = fym;
            end
            ST_Y3: begin
                mul_a = sixt_y;
                mul_b = fym;
            end
            ST_Y4: begin
                mul_a = $signed(MW'(t3_reg));
                mul_b = inner;
            end
            ST_L1: begin
                mul_a = $signed(MW'(fu_reg));
                mul_b = MW'(g_ba) - MW'(g_aa);
            end
            ST_L2: begin
                mul_a = $signed(MW'(fu_reg));
                mul_b = MW'(g_bb) - MW'(g_ab);
            end
            ST_L3: begin
                mul_a = $signed(MW'(fv_reg));
                mul_b = MW'(hi_calc) - MW'(lo_reg);
            end
            ST_L4: begin
                mul_a = MW'(nv_calc);
                mul_b = $signed(MW'(amp_reg));
            end
            ST_ACC: begin
                mul_a = $signed(MW'(amp_reg));
                mul_b = $signed(MW'(persist_reg));
            end
            ST_DIV_LOAD: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        n_next       = n_reg;
        oct_next     = oct_reg;
        amp_next     = amp_reg;
        total_next   = total_reg;
        weight_next  = weight_reg;
        ha_next      = ha_reg;
        hb_next      = hb_reg;
        h_aa_next    = h_aa_reg;
        h_ab_next    = h_ab_reg;
        h_ba_next    = h_ba_reg;
        h_bb_next    = h_bb_reg;
        t3_next      = t3_reg;
        fu_next      = fu_reg;
        fv_next      = fv_reg;
        lo_next      = lo_reg;
        m_value_next = m_value_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_opcode == OP_EVAL)) begin
                    cx_next     = s_coord_x[COORD_KEEP-1:0];
                    cy_next     = s_coord_y[COORD_KEEP-1:0];
                    n_next      = n_sel;
                    oct_next    = '0;
                    amp_next    = AMP_ONE;
                    total_next  = '0;
                    weight_next = '0;
                end
            end
            ST_GX1: ha_next = ram_rd_data + gy;
            ST_X3: begin
                hb_next = ram_rd_data + gy;
                t3_next = p_hi;
            end
            ST_X4:  h_aa_next = ram_rd_data[HASH_W-1:0];
            ST_Y1: begin
                h_ab_next = ram_rd_data[HASH_W-1:0];
                fu_next   = fade_res;
            end
            ST_Y2:  h_ba_next = ram_rd_data[HASH_W-1:0];
            ST_Y3: begin
                h_bb_next = ram_rd_data[HASH_W-1:0];
                t3_next   = p_hi;
            end
            ST_L1:  fv_next = fade_res;
            ST_L2:  lo_next = g_aa + lerp_add;
            ST_ACC: begin
                total_next  = total_reg + TOT_W'(mul_p);
                weight_next = weight_reg + WT_W'(amp_reg);
            end
            ST_AMP: begin
                amp_next = mul_p[16 +: AMP_W];
                oct_next = oct_reg + OCT_W'(1);
                cx_next  = cx_reg << 1;
                cy_next  = cy_reg << 1;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (total_reg[TOT_W-1]) begin
                        m_value_next = -$signed(q_sat);
                    end else if (q_sat > OUT_MAX) begin
                        m_value_next = $signed(OUT_MAX);
                    end else begin
                        m_value_next = $signed(q_sat);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- configuration
    always_comb begin
        oct_count_next = oct_count_reg;
        persist_next   = persist_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_OCTAVE_COUNT: oct_count_next = pwdata[OCT_CNT_W-1:0];
                REG_PERSISTENCE:  persist_next   = pwdata[PERS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OCTAVE_COUNT: prdata = PDATA_W'(oct_count_reg);
            REG_PERSISTENCE:  prdata = PDATA_W'(persist_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            oct_count_reg <= OCT_CNT_RESET;
            persist_reg   <= PERS_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            oct_count_reg <= oct_count_next;
            persist_reg   <= persist_next;
        end
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        n_reg       <= n_next;
        oct_reg     <= oct_next;
        amp_reg     <= amp_next;
        total_reg   <= total_next;
        weight_reg  <= weight_next;
        ha_reg      <= ha_next;
        hb_reg      <= hb_next;
        h_aa_reg    <= h_aa_next;
        h_ab_reg    <= h_ab_next;
        h_ba_reg    <= h_ba_next;
        h_bb_reg    <= h_bb_next;
        t3_reg      <= t3_next;
        fu_reg      <= fu_next;
        fv_reg      <= fv_next;
        lo_reg      <= lo_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_value_reg;

    // ---------------------------------------------------------------- assertions
    a_oct_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GX) |-> (oct_reg < n_reg))
        else $error("octave counter past octave count");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result word raised outside final state");

    a_weight_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_LOAD) |-> (weight_reg >= WT_W'(AMP_ONE)))
        else $error("weight below unity at divide");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ----- tb/noise_watch.sv -----
// Watcher for the octave noise block: tracks table and registers, predicts and checks results.
`timescale 1ns / 1ps

module noise_watch
    import opn_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire logic                      s_opcode,
    input  wire logic [7:0]                s_table_index,
    input  wire logic [7:0]                s_table_value,
    input  wire logic signed [COORD_W-1:0] s_coord_x,
    input  wire logic signed [COORD_W-1:0] s_coord_y,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire logic signed [OUT_W-1:0]   m_noise_value,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic                      pready,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output int                             error_count,
    output int                             results_pending
);

    localparam int     OCTAVES_MAX = 8;
    localparam int     FB          = 16;
    localparam longint ONE_Q       = 65536;
    localparam longint SAT_HI      = 131071;
    localparam longint SAT_LO      = -131072;

    logic [7:0]           perm [TABLE_SIZE];
    logic [OCT_CNT_W-1:0] octaves = OCT_CNT_RESET;
    logic [PERS_W-1:0]    persist = PERS_RESET;
    logic [OUT_W-1:0]     noise_due [$];
    logic [OUT_W-1:0]     want;
    int                   mismatches = 0;
    int                   outstanding = 0;
    int                   words_seen = 0;

    assign error_count     = mismatches;
    assign results_pending = outstanding;

    function automatic longint fade_q16(longint t);
        longint t2, t3, inner, f;
        t2    = (t * t) >>> FB;
        t3    = (t2 * t) >>> FB;
        inner = (((6 * t - 15 * ONE_Q) * t) >>> FB) + 10 * ONE_Q;
        f     = (t3 * inner) >>> FB;
        if (f < 0) f = 0;
        if (f > ONE_Q) f = ONE_Q;
        return f;
    endfunction

    // hash bit 2 swaps the axes, bits 0 and 1 flip the signs
    function automatic longint corner_dot(logic [7:0] hash, longint x, longint y);
        longint u, v;
        u = hash[2] ? y : x;
        v = hash[2] ? x : y;
        if (hash[0]) u = -u;
        if (hash[1]) v = -v;
        return u + v;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> FB);
    endfunction

    function automatic longint octave_sample(logic [63:0] cx, logic [63:0] cy);
        logic [7:0] gx, gx1, gy, ca, ca1, cb, cb1;
        longint     x, y, u, v, lo, hi;
        gx  = cx[23:16];
        gy  = cy[23:16];
        gx1 = gx + 8'd1;
        x   = {48'd0, cx[15:0]};
        y   = {48'd0, cy[15:0]};
        u   = fade_q16(x);
        v   = fade_q16(y);
        ca  = perm[gx] + gy;
        cb  = perm[gx1] + gy;
        ca1 = ca + 8'd1;
        cb1 = cb + 8'd1;
        lo  = blend(corner_dot(perm[ca], x, y), corner_dot(perm[cb], x - ONE_Q, y), u);
        hi  = blend(corner_dot(perm[ca1], x, y - ONE_Q),
                    corner_dot(perm[cb1], x - ONE_Q, y - ONE_Q), u);
        return blend(lo, hi, v);
    endfunction

    function automatic logic [OUT_W-1:0] octave_noise(logic [31:0] px, logic [31:0] py);
        int          n, i;
        logic [63:0] x0, y0, amp, weight, mag, q;
        longint      total, r;
        n = (octaves == 0) ? 1 : int'(octaves);
        if (n > OCTAVES_MAX) n = OCTAVES_MAX;
        x0     = {{32{px[31]}}, px};
        y0     = {{32{py[31]}}, py};
        amp    = 64'd65536;
        weight = 64'd0;
        total  = 0;
        for (i = 0; i < n; i++) begin
            total  += octave_sample(x0 << i, y0 << i) * longint'(amp);
            weight += amp;
            amp     = (amp * persist) >> 16;
        end
        mag = (total < 0) ? 64'(-total) : 64'(total);
        q   = mag / weight;
        if (q > 64'd131072) q = 64'd131072;
        r = (total < 0) ? -longint'(q) : longint'(q);
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        return r[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100) $display("%0t ns: mismatch: %s", $time / 1000, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            octaves = OCT_CNT_RESET;
            persist = PERS_RESET;
            noise_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_OCTAVE_COUNT: octaves = pwdata[OCT_CNT_W-1:0];
                    REG_PERSISTENCE:  persist = pwdata[PERS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_LOAD) perm[s_table_index] = s_table_value;
                else noise_due = {noise_due, octave_noise(s_coord_x, s_coord_y)};
            end
            if (m_valid && m_ready) begin
                words_seen++;
                if (noise_due.size() == 0) begin
                    report_mismatch($sformatf("result word %0d (%0d) with nothing outstanding",
                                              words_seen, m_noise_value));
                end else begin
                    want = noise_due.pop_front();
                    if (m_noise_value !== want)
                        report_mismatch($sformatf("result word %0d: noise_value %0d, want %0d",
                                                  words_seen, m_noise_value, $signed(want)));
                end
            end
        end
        outstanding <= noise_due.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the octave noise block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import opn_pkg::*;

    localparam int RANDOM_WORDS  = 180;
    localparam int PHASES        = 9;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 900;
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam logic [PADDR_W-1:0] ADDR_OCTAVES = PADDR_W'(4 * REG_OCTAVE_COUNT);
    localparam logic [PADDR_W-1:0] ADDR_PERSIST = PADDR_W'(4 * REG_PERSISTENCE);

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_opcode      = OP_LOAD;
    logic [7:0]                s_table_index = '0;
    logic [7:0]                s_table_value = '0;
    logic signed [COORD_W-1:0] s_coord_x     = '0;
    logic signed [COORD_W-1:0] s_coord_y     = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic signed [OUT_W-1:0]   m_noise_value;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [PADDR_W-1:0]        paddr         = '0;
    logic [PDATA_W-1:0]        pwdata        = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    int errors;
    int pending;
    int cycles      = 0;
    int send_idle   = 17;
    int recv_idle   = 55;
    int hold_tokens = 0;
    int holds_done  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    octave_perlin_noise_2d dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_noise_value (m_noise_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    noise_watch watch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_table_index   (s_table_index),
        .s_table_value   (s_table_value),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_noise_value   (m_noise_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .error_count     (errors),
        .results_pending (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_done != hold_tokens) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                holds_done++;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_word(logic op, logic [7:0] idx, logic [7:0] val,
                             logic [31:0] x, logic [31:0] y);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_opcode      = op;
        s_table_index = idx;
        s_table_value = val;
        s_coord_x     = x;
        s_coord_y     = y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and let the block go quiet
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_word();
        logic [31:0] x, y;
        x = $urandom;
        y = $urandom;
        case ($urandom_range(11))
            0, 1, 2: send_word(OP_LOAD, 8'($urandom), 8'($urandom), x, y);
            3, 4: begin
                // near the origin, both signs
                x = 32'($urandom_range(32'h80000)) - 32'h40000;
                y = 32'($urandom_range(32'h80000)) - 32'h40000;
                send_word(OP_EVAL, 8'($urandom), 8'($urandom), x, y);
            end
            5, 6: begin
                // cell edges and centres
                case ($urandom_range(3))
                    0: x[15:0] = 16'h0000;
                    1: x[15:0] = 16'hFFFF;
                    2: x[15:0] = 16'h8000;
                    default: x[15:0] = 16'h0001;
                endcase
                y[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                send_word(OP_EVAL, 8'($urandom), 8'($urandom), x, y);
            end
            default: send_word(OP_EVAL, 8'($urandom), 8'($urandom), x, y);
        endcase
    endtask

    initial begin
        logic [7:0]  order [TABLE_SIZE];
        logic [7:0]  swap;
        int unsigned oct_plan [PHASES];
        int unsigned pers_plan [PHASES];
        int          i, j, ph, k;

        oct_plan  = '{4, 0, 15, 8, 1, 9, 2, 0, 0};
        pers_plan = '{32768, 0, 65535, 65535, 32768, 0, 1, 0, 0};
        oct_plan[7]  = $urandom_range(15);
        pers_plan[7] = $urandom_range(65535);
        oct_plan[8]  = $urandom_range(1, 8);
        pers_plan[8] = $urandom_range(65535);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // fill every table entry with a shuffled permutation before any evaluation
        for (i = 0; i < TABLE_SIZE; i++) order[i] = 8'(i);
        for (i = TABLE_SIZE - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < TABLE_SIZE; i++)
            send_word(OP_LOAD, 8'(i), order[i], $urandom, $urandom);

        // directed words at the reset setting
        send_word(OP_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_EVAL, 8'hFF, 8'hFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(OP_EVAL, 8'hFF, 8'h00, 32'h8000_0000, 32'h8000_0000);
        send_word(OP_EVAL, 8'h00, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_EVAL, 8'h5A, 8'hA5, 32'hFFFF_FFFF, 32'h0000_0001);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'h0000_FFFF, 32'hFFFF_0000);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'h0001_0000, 32'h0001_8000);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'h00FF_8000, 32'h00FF_4000);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'hFF00_0000, 32'h0100_0000);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'h1234_5678, 32'h9ABC_DEF0);
        send_word(OP_LOAD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_LOAD, 8'h80, order[8'h80] ^ 8'h5A, 32'h0, 32'h0);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'h00FF_FFFF, 32'h00FF_FFFF);
        send_word(OP_EVAL, 8'hFF, 8'hFF, 32'h0080_8000, 32'hFF7F_8000);
        send_word(OP_EVAL, 8'h00, 8'h00, 32'hFFFF_8000, 32'hFFFF_8000);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                if (ph == 3) begin
                    send_idle = 55;
                    recv_idle = 17;
                end else if (ph == 6) begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                apb_write(ADDR_OCTAVES, PDATA_W'(oct_plan[ph]));
                apb_write(ADDR_PERSIST, PDATA_W'(pers_plan[ph]));
            end
            for (k = 0; k < RANDOM_WORDS / PHASES; k++) begin
                if ((ph == 1 || ph == 7) && k == 4) hold_tokens++;
                random_word();
            end
        end

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
